@@ design/four_level_page_table_engine_defines.svh @@
// ----------------------------------------------------------------------------
// Four-level page table engine: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define FLPTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/flpte_pkg.sv @@
// ----------------------------------------------------------------------------
// Four-level page table engine package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package flpte_pkg;

    localparam int FLPTE_TABLE_FRAMES = 64;
    localparam int ENTRIES_PER_TABLE  = 512;
    localparam int IDX_W              = 9;
    localparam int MAX_PAGES          = 4096;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PAGE,
        S_RD,
        S_CHK,
        S_ZERO,
        S_LINK,
        S_LEAF,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clear_step;
        logic    zero_start;
        logic    zero_step;
        logic    link_write;
        logic    descend;
        logic    leaf_write;
        logic    fail;
        status_t code;
        logic    xlate_done;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic clear_last;
        logic zero_last;
        logic link_ok;
        logic full;
        logic at_leaf;
        logic pages_left;
    } sts_t;

endpackage

@@ design/flpte_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flpte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/flpte_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page table engine controller
// Sequences clearing, walks, table allocation and leaf updates.
// ----------------------------------------------------------------------------
module flpte_ctrl
    import flpte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_DONE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_OUT;
                    if (sts.op == OP_MAP || sts.op == OP_UNMAP)
                    begin
                        state_next = S_PAGE;
                    end
                    else if (sts.op == OP_XLATE)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_PAGE:
            begin
                state_next = sts.pages_left ? S_RD : S_OUT;
            end
            S_RD:
            begin
                if (sts.at_leaf && sts.op != OP_XLATE)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.at_leaf)
                begin
                    cmd.xlate_done = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.link_ok)
                begin
                    cmd.descend = 1'b1;
                    state_next = S_RD;
                end
                else if (sts.op != OP_MAP)
                begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_MISSING;
                    state_next = S_OUT;
                end
                else if (sts.full)
                begin
                    cmd.fail = 1'b1;
                    cmd.code = ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.zero_start = 1'b1;
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (sts.zero_last)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.link_write = 1'b1;
                state_next = S_RD;
            end
            S_LEAF:
            begin
                cmd.leaf_write = 1'b1;
                state_next = S_PAGE;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ design/flpte_datapath.sv @@
// ----------------------------------------------------------------------------
// Page table engine datapath
// Request registers, table store, link decode, allocator and result.
// ----------------------------------------------------------------------------
module flpte_datapath
    import flpte_pkg::*;
#(
    parameter int TABLE_FRAMES = FLPTE_TABLE_FRAMES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [39:0] table_base_frame,
    input  logic [1:0]  in_operation,
    input  logic [47:0] in_virtual_address,
    input  logic [39:0] in_physical_frame,
    input  logic [12:0] in_page_count,
    input  logic        in_user_page,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [1:0]  status,
    output logic [51:0] physical_address,
    output logic [12:0] pages_done
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int AW    = $clog2(DEPTH);

    op_t             op_reg;
    logic [47:0]     va_reg;
    logic [39:0]     frame_reg;
    logic [12:0]     count_reg;
    logic [12:0]     done_reg;
    logic            user_reg;
    logic [FW-1:0]   table_reg;
    logic [1:0]      level_reg;
    logic [FW:0]     next_free_reg;
    logic [IDX_W-1:0] zcnt_reg;
    logic [AW-1:0]   clr_reg;
    status_t         status_reg;
    logic [51:0]     pa_reg;

    logic [IDX_W-1:0] idx;
    logic [AW-1:0]    slot_addr;
    logic [AW-1:0]    waddr;
    logic [63:0]      wdata;
    logic [63:0]      rdata;
    logic             we;
    logic [39:0]      link_off;
    logic [39:0]      child_frame;

    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign slot_addr   = AW'({table_reg, idx});
    assign link_off    = rdata[51:12] - table_base_frame;
    assign child_frame = table_base_frame + 40'(next_free_reg[FW-1:0]);

    assign we = cmd.clear_step | cmd.zero_step | cmd.link_write | cmd.leaf_write;

    always_comb
    begin
        if (cmd.clear_step)
        begin
            waddr = clr_reg;
        end
        else if (cmd.zero_step)
        begin
            waddr = AW'({next_free_reg[FW-1:0], zcnt_reg});
        end
        else
        begin
            waddr = slot_addr;
        end
        if (cmd.link_write)
        begin
            wdata = {12'h000, child_frame, 12'h007};
        end
        else if (cmd.leaf_write && op_reg == OP_MAP)
        begin
            wdata = {12'h000, frame_reg, 9'h000, user_reg, 2'b11};
        end
        else
        begin
            wdata = '0;
        end
    end

    flpte_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (slot_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_NONE;
            table_reg     <= '0;
            level_reg     <= '0;
            next_free_reg <= (FW+1)'(1);
            zcnt_reg      <= '0;
            clr_reg       <= '0;
            done_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                op_reg     <= op_t'(in_operation);
                count_reg  <= (in_page_count > 13'(MAX_PAGES)) ? 13'(MAX_PAGES)
                                                               : in_page_count;
                done_reg   <= '0;
                status_reg <= ST_DONE;
                table_reg  <= '0;
                level_reg  <= '0;
            end
            if (cmd.zero_start)
            begin
                zcnt_reg <= '0;
            end
            if (cmd.zero_step)
            begin
                zcnt_reg <= zcnt_reg + IDX_W'(1);
            end
            if (cmd.descend)
            begin
                table_reg <= link_off[FW-1:0];
                level_reg <= level_reg + 2'd1;
            end
            if (cmd.link_write)
            begin
                table_reg     <= next_free_reg[FW-1:0];
                next_free_reg <= next_free_reg + (FW+1)'(1);
                level_reg     <= level_reg + 2'd1;
            end
            if (cmd.leaf_write)
            begin
                done_reg  <= done_reg + 13'd1;
                table_reg <= '0;
                level_reg <= '0;
            end
            if (cmd.fail)
            begin
                status_reg <= cmd.code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            va_reg    <= in_virtual_address;
            frame_reg <= in_physical_frame;
            user_reg  <= in_user_page;
            pa_reg    <= '0;
        end
        if (cmd.leaf_write)
        begin
            va_reg    <= va_reg + 48'h1000;
            frame_reg <= frame_reg + 40'd1;
        end
        if (cmd.xlate_done)
        begin
            pa_reg <= (|rdata[63:12]) ? {rdata[51:12], va_reg[11:0]} : '0;
        end
    end

    always_comb
    begin
        sts.op         = cmd.load ? op_t'(in_operation) : op_reg;
        sts.clear_last = (clr_reg == AW'(DEPTH - 1));
        sts.zero_last  = (zcnt_reg == IDX_W'(ENTRIES_PER_TABLE - 1));
        sts.link_ok    = (|rdata[63:12]) && (link_off < 40'(TABLE_FRAMES));
        sts.full       = (next_free_reg == (FW+1)'(TABLE_FRAMES));
        sts.at_leaf    = (level_reg == 2'd3);
        sts.pages_left = (done_reg != count_reg);
    end

    assign status           = status_reg;
    assign physical_address = pa_reg;
    assign pages_done       = (op_reg == OP_MAP || op_reg == OP_UNMAP) ? done_reg : '0;

endmodule

@@ design/four_level_page_table_engine.sv @@
// Four-level page table engine: maps, unmaps and translates 48-bit virtual
// addresses in an x86-64 style tree held in a local store of TABLE_FRAMES
// 4 KiB frames (one 64-bit entry read or written per cycle). After reset the
// store is cleared one entry a cycle, all TABLE_FRAMES*512 entries, before
// the first request is taken. One request is in flight at a time. Translate
// walks the tree by dependent store reads, one per level; map and unmap walk
// it once per page and then write the leaf entry, and each new table frame
// is zeroed entry by entry before it is linked.
// ----------------------------------------------------------------------------
// Four-level page table engine
// Top level: APB register, stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module four_level_page_table_engine
    import flpte_pkg::*;
#(
    parameter int TABLE_FRAMES = FLPTE_TABLE_FRAMES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // virtual_address, physical_frame, page_count, user_page
    input  logic [1:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // physical_address, pages_done
    output logic [1:0]   m_tuser   // status
);

    localparam logic [2:0] ADDR_BASE = 3'd0;

    logic [39:0] base_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic [1:0]  status;
    logic [51:0] physical_address;
    logic [12:0] pages_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_BASE)
        begin
            base_reg <= pwdata[39:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BASE) ? {24'h0, base_reg} : '0;

    flpte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    flpte_datapath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .table_base_frame   (base_reg),
        .in_operation       (s_tuser),
        .in_virtual_address (s_tdata[47:0]),
        .in_physical_frame  (s_tdata[87:48]),
        .in_page_count      (s_tdata[100:88]),
        .in_user_page       (s_tdata[101]),
        .cmd                (cmd),
        .sts                (sts),
        .status             (status),
        .physical_address   (physical_address),
        .pages_done         (pages_done)
    );

    assign m_tdata = {7'h00, pages_done, physical_address};
    assign m_tuser = status;

endmodule

@@ design/flpte_checker.sv @@
// ----------------------------------------------------------------------------
// Page table engine port checker
// Checks request and result behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "four_level_page_table_engine_defines.svh"

module flpte_checker
    import flpte_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    `FLPTE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `FLPTE_ASSERT_NOW(a_one_req, s_tready, !m_tvalid, "request taken with result pending")
    `FLPTE_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "second request while busy")
    `FLPTE_ASSERT_NOW(a_fail_pa, m_tvalid && m_tuser != ST_DONE, m_tdata[51:0] == 52'd0, "address on failure")

endmodule

bind four_level_page_table_engine flpte_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
